// File: rtl/c3kf_pkg.sv
// Package for the 3x3 multi-kernel image filter: register indexes, kernel codes,
// reset values, reciprocal constants and the result-source type.
// No dependencies; used by conv3x3_multi_kernel_filter.
`timescale 1ns / 1ps
`default_nettype none

package c3kf_pkg;

    // Default sizing handed to the top level parameters.
    localparam int DEF_MAX_WIDTH    = 2048;
    localparam int DEF_MAX_CHANNELS = 3;

    // Fixed field widths.
    localparam int DATA_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int H_W        = 16;
    // The input row count runs one past the frame height while flushing.
    localparam int IN_ROW_W   = H_W + 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THREE_CHANNELS = 2'd3;

    // Kernel codes held in the filter_mode register.
    localparam logic [2:0] MODE_SMOOTH   = 3'd0;
    localparam logic [2:0] MODE_GAUSSIAN = 3'd1;
    localparam logic [2:0] MODE_SHARPEN  = 3'd2;
    localparam logic [2:0] MODE_EMBOSS   = 3'd3;
    localparam logic [2:0] MODE_MEAN_REM = 3'd4;

    // Register values after reset.
    localparam logic [2:0] RST_MODE   = MODE_SMOOTH;
    localparam int         RST_WIDTH  = 640;
    localparam int         RST_HEIGHT = 480;
    localparam logic       RST_THREE  = 1'b1;

    // Exact division by 9 and by 3 for operands below 2**15:
    // floor(n / 9) = (n * 7282) >> 16 and floor(n / 3) = (n * 21846) >> 16.
    localparam int          MUL_A_W     = 12;
    localparam int          MUL_K_W     = 15;
    localparam int          RECIP_SHIFT = 16;
    localparam logic [14:0] RECIP_9     = 15'd7282;
    localparam logic [14:0] RECIP_3     = 15'd21846;

    // Where an output byte comes from.
    typedef enum logic [1:0] {
        SEL_KERNEL,   // kernel over the 3x3 window
        SEL_CENTER,   // border pixel: window centre passed through
        SEL_EDGE,     // right border pixel read back from the upper line store
        SEL_MID       // flush byte read back from the middle line store
    } src_sel_t;

endpackage

`default_nettype wire

// File: rtl/conv3x3_multi_kernel_filter.sv
// 3x3 multi-kernel image filter: line stores, window and kernels in one module.
// Depends on c3kf_pkg (register indexes, kernel codes, reset values, constants).
`timescale 1ns / 1ps
`default_nettype none

// Usage
// -----
// Input items (s_*) carry one image byte each, in raster order with channels
// interleaved (grey, or R,G,B per pixel). s_tuser set marks a drain item that
// carries no byte; drains only count once the whole frame has been taken in,
// and they push out the tail of the filtered frame. Any byte item sent after the
// frame is complete acts as a drain as well. Result items (m_*) carry the
// filtered byte, delayed by one row plus one pixel; m_tlast marks the last byte
// of the output frame, after which the block starts on the next frame.
// Throughput is one item per cycle while the result side is not stalled. An
// accepted item passes through the synchronous line store read, the shift of
// the 3x3 window with the upper store write-back, and the kernel (adder tree
// plus a shared reciprocal multiplier) before it reaches the result register.
// Each stage has its own valid bit, so a stalled receiver stops the pipeline
// from the output back, and empty stages still take new items meanwhile.
// The configuration channel is always ready; any write restarts the frame.
// Reset restores the register defaults and clears all counters and valids.
// The line stores are not cleared: within a frame every store position is
// written before it can reach the output, so stale contents never show.

module conv3x3_multi_kernel_filter #(
    parameter int MAX_WIDTH    = c3kf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_CHANNELS = c3kf_pkg::DEF_MAX_CHANNELS
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Configuration write channel.
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [c3kf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [c3kf_pkg::CFG_DATA_W-1:0]   cfg_data,
    // Input stream.
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [7:0]                        s_tdata,   // [7:0] sample
    input  wire logic                              s_tuser,   // [0] drain
    // Result stream.
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [7:0]                             m_tdata,   // [7:0] result_sample
    output logic                                   m_tlast    // end_of_frame
);

    localparam int STORE_DEPTH = MAX_WIDTH * MAX_CHANNELS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int WC_W        = $clog2(STORE_DEPTH + 1);
    localparam int OC_W        = WC_W + 1;
    localparam int EW_W        = $clog2(MAX_WIDTH + 1);
    localparam int WIN_DEPTH   = 2 * MAX_CHANNELS + 1;
    localparam int WIN_IDX_W   = $clog2(WIN_DEPTH);
    localparam int CH_HI       = (MAX_CHANNELS >= 3) ? 3 : 1;
    localparam int ROW_W       = c3kf_pkg::IN_ROW_W;
    localparam int H_W         = c3kf_pkg::H_W;
    localparam int RST_EW      = (c3kf_pkg::RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH
                                                                   : c3kf_pkg::RST_WIDTH;
    localparam logic CH3_OK    = (MAX_CHANNELS >= 3);
    localparam logic RST_CH3   = c3kf_pkg::RST_THREE & CH3_OK;
    localparam int RST_WC      = RST_CH3 ? 3 * RST_EW : RST_EW;

    // ------------------------------------------------------------------
    // Configuration registers. Clamped width, channel count and the row
    // length in bytes are worked out when a register is written.
    // ------------------------------------------------------------------
    logic [2:0]       mode_reg;
    logic [EW_W-1:0]  ew_reg;
    logic [H_W-1:0]   h_reg;
    logic             ch3_reg;
    logic [WC_W-1:0]  wc_reg;

    logic             cfg_we;
    logic [11:0]      w_raw;
    logic [EW_W-1:0]  ew_new;
    logic             ch3_new;
    logic [WC_W-1:0]  wc_new;
    logic [H_W-1:0]   h_new;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid & cfg_ready;
    assign w_raw     = cfg_data[11:0];

    always_comb begin
        ew_new  = ew_reg;
        ch3_new = ch3_reg;
        h_new   = h_reg;
        if (cfg_index == c3kf_pkg::CFG_IMAGE_WIDTH) begin
            if (32'(w_raw) > 32'(MAX_WIDTH)) begin
                ew_new = EW_W'(MAX_WIDTH);
            end else if (w_raw < 12'd3) begin
                ew_new = EW_W'(3);
            end else begin
                ew_new = EW_W'(w_raw);
            end
        end
        if (cfg_index == c3kf_pkg::CFG_THREE_CHANNELS) begin
            ch3_new = cfg_data[0] & CH3_OK;
        end
        if (cfg_index == c3kf_pkg::CFG_IMAGE_HEIGHT) begin
            h_new = (cfg_data < 16'd3) ? 16'd3 : cfg_data;
        end
        wc_new = ch3_new ? (WC_W'(ew_new) + (WC_W'(ew_new) << 1)) : WC_W'(ew_new);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= c3kf_pkg::RST_MODE;
            ew_reg   <= EW_W'(RST_EW);
            h_reg    <= H_W'(c3kf_pkg::RST_HEIGHT);
            ch3_reg  <= RST_CH3;
            wc_reg   <= WC_W'(RST_WC);
        end else if (cfg_we) begin
            if (cfg_index == c3kf_pkg::CFG_FILTER_MODE) begin
                mode_reg <= cfg_data[2:0];
            end
            ew_reg  <= ew_new;
            h_reg   <= h_new;
            ch3_reg <= ch3_new;
            wc_reg  <= wc_new;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline handshake. Stage 1 holds the line store read data, stage 2
    // the shifted window, and the result register feeds the m_ channel.
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, out_v_reg;
    logic en0, en1, en2;

    assign en2      = !out_v_reg || m_tready;
    assign en1      = !v2_reg || en2;
    assign en0      = !v1_reg || en1;
    assign s_tready = en0;

    // ------------------------------------------------------------------
    // Stage 0: position counters, result selection and store addresses.
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0] in_col_reg, in_col_next;
    logic [ROW_W-1:0]  in_row_reg, in_row_next;
    logic [ADDR_W-1:0] out_col_reg, out_col_next;
    logic [H_W-1:0]    out_row_reg, out_row_next;

    logic [WC_W-1:0]   ch_v;
    logic [WC_W-1:0]   k_ext;
    logic [WC_W-1:0]   k_inc;
    logic [OC_W-1:0]   oc_ext;
    logic              k_lt_ch;
    logic              in_phase;
    logic              at_h;
    logic              inner;
    logic              out_col_wrap;
    logic              eof0;
    logic              emit0;
    c3kf_pkg::src_sel_t sel0;
    logic [ADDR_W-1:0] edge_addr;
    logic [ADDR_W-1:0] mid_addr;
    logic              acc;
    logic              item;
    logic              mid_we;
    logic              fwd_hit;

    assign ch_v     = ch3_reg ? WC_W'(3) : WC_W'(1);
    assign k_ext    = WC_W'(in_col_reg);
    assign k_inc    = k_ext + WC_W'(1);
    assign oc_ext   = OC_W'(out_col_reg);
    assign k_lt_ch  = k_ext < ch_v;
    assign in_phase = in_row_reg < {1'b0, h_reg};
    assign at_h     = in_row_reg == {1'b0, h_reg};
    assign edge_addr = ADDR_W'(wc_reg - ch_v + k_ext);

    // Interior pixels get the kernel; the outermost pixels pass through.
    assign inner = (out_row_reg != '0)
                && (({1'b0, out_row_reg} + 17'd1) < {1'b0, h_reg})
                && (WC_W'(out_col_reg) >= ch_v)
                && ((oc_ext + OC_W'(ch_v)) < OC_W'(wc_reg));
    assign out_col_wrap = (oc_ext + OC_W'(1)) >= OC_W'(wc_reg);
    assign eof0 = ((({1'b0, out_row_reg} + 17'd1) >= {1'b0, h_reg})) && out_col_wrap;

    always_comb begin
        if (in_phase) begin
            if (k_lt_ch) begin
                emit0 = in_row_reg >= ROW_W'(2);
                sel0  = c3kf_pkg::SEL_EDGE;
            end else begin
                emit0 = in_row_reg != '0;
                sel0  = inner ? c3kf_pkg::SEL_KERNEL : c3kf_pkg::SEL_CENTER;
            end
        end else begin
            emit0 = 1'b1;
            sel0  = (at_h && k_lt_ch) ? c3kf_pkg::SEL_EDGE : c3kf_pkg::SEL_MID;
        end
    end

    // While flushing, the middle store is read one pixel behind on the row
    // just past the frame, then at the wrapped right border on the row after.
    always_comb begin
        if (!in_phase && at_h && !k_lt_ch) begin
            mid_addr = ADDR_W'(k_ext - ch_v);
        end else if (!in_phase && !at_h && k_lt_ch) begin
            mid_addr = edge_addr;
        end else begin
            mid_addr = in_col_reg;
        end
    end

    assign acc    = s_tvalid && s_tready;
    // A drain before the frame is complete does nothing at all.
    assign item   = acc && (!in_phase || !s_tuser);
    assign mid_we = item && in_phase;

    always_comb begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (cfg_we) begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end else if (item) begin
            if (k_inc >= wc_reg) begin
                in_col_next = '0;
                in_row_next = in_row_reg + ROW_W'(1);
            end else begin
                in_col_next = ADDR_W'(k_inc);
            end
            if (emit0) begin
                if (eof0) begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end else if (out_col_wrap) begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + H_W'(1);
                end else begin
                    out_col_next = ADDR_W'(oc_ext + OC_W'(1));
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    // ------------------------------------------------------------------
    // Line stores. The middle store takes the new byte at acceptance; the
    // upper store gets the old middle byte when that item leaves stage 1,
    // once it has been read. With one channel the left-border read of the
    // next row can hit the entry being written back in that same cycle, so
    // the written byte is forwarded.
    // ------------------------------------------------------------------
    logic [7:0] upper_mem  [STORE_DEPTH];
    logic [7:0] middle_mem [STORE_DEPTH];

    logic [7:0]           mid_rd_reg;
    logic [7:0]           up_rd_reg;
    logic [7:0]           up_edge_rd_reg;
    logic                 fwd_reg;
    logic [7:0]           fwd_data_reg;

    logic                 p1_shift_reg;
    logic [ADDR_W-1:0]    p1_addr_reg;
    logic [7:0]           p1_sample_reg;
    logic                 p1_emit_reg;
    c3kf_pkg::src_sel_t   p1_sel_reg;
    logic                 p1_eof_reg;

    logic                 fire1;
    logic                 up_we;
    logic [7:0]           edge_val;

    assign fire1   = v1_reg && en1;
    assign up_we   = fire1 && p1_shift_reg;
    assign fwd_hit = v1_reg && p1_shift_reg && (p1_addr_reg == edge_addr);

    always_ff @(posedge aclk) begin
        if (mid_we) begin
            middle_mem[in_col_reg] <= s_tdata;
        end
        if (acc) begin
            mid_rd_reg <= middle_mem[mid_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (up_we) begin
            upper_mem[p1_addr_reg] <= mid_rd_reg;
        end
        if (acc) begin
            up_rd_reg      <= upper_mem[in_col_reg];
            up_edge_rd_reg <= upper_mem[edge_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            fwd_reg       <= fwd_hit;
            fwd_data_reg  <= mid_rd_reg;
            p1_shift_reg  <= in_phase;
            p1_addr_reg   <= in_col_reg;
            p1_sample_reg <= s_tdata;
            p1_emit_reg   <= emit0;
            p1_sel_reg    <= sel0;
            p1_eof_reg    <= eof0;
        end
    end

    assign edge_val = fwd_reg ? fwd_data_reg : up_edge_rd_reg;

    // ------------------------------------------------------------------
    // Stage 1: shift the window by one byte and pass the read-back byte on.
    // ------------------------------------------------------------------
    logic [7:0] win_reg [3][WIN_DEPTH];

    always_ff @(posedge aclk) begin
        if (up_we) begin
            for (int r = 0; r < 3; r++) begin
                for (int i = WIN_DEPTH - 1; i > 0; i--) begin
                    win_reg[r][i] <= win_reg[r][i-1];
                end
            end
            win_reg[0][0] <= up_rd_reg;
            win_reg[1][0] <= mid_rd_reg;
            win_reg[2][0] <= p1_sample_reg;
        end
    end

    c3kf_pkg::src_sel_t p2_sel_reg;
    logic               p2_eof_reg;
    logic [7:0]         p2_val_reg;

    always_ff @(posedge aclk) begin
        if (en1) begin
            p2_sel_reg <= p1_sel_reg;
            p2_eof_reg <= p1_eof_reg;
            p2_val_reg <= (p1_sel_reg == c3kf_pkg::SEL_EDGE) ? edge_val : mid_rd_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: kernel over the window, then the result register.
    // ------------------------------------------------------------------
    logic [WIN_IDX_W-1:0] ci, c2i;
    logic [11:0] tl, t, tr, l, c, r, bl, b, br;
    logic [11:0] sum9;
    logic [11:0] gsum;
    logic [13:0] sh_pos, sh_neg;
    logic        sh_is_neg;
    logic [11:0] sh_abs;
    logic [c3kf_pkg::MUL_A_W-1:0] mul_a;
    logic [c3kf_pkg::MUL_K_W-1:0] mul_k;
    logic [c3kf_pkg::MUL_A_W+c3kf_pkg::MUL_K_W-1:0] prod;
    logic [7:0]  quot;
    logic [7:0]  kern_val;
    logic [7:0]  res_val;

    assign ci  = ch3_reg ? WIN_IDX_W'(CH_HI) : WIN_IDX_W'(1);
    assign c2i = ch3_reg ? WIN_IDX_W'(2 * CH_HI) : WIN_IDX_W'(2);

    assign tl = 12'(win_reg[0][c2i]);
    assign t  = 12'(win_reg[0][ci]);
    assign tr = 12'(win_reg[0][0]);
    assign l  = 12'(win_reg[1][c2i]);
    assign c  = 12'(win_reg[1][ci]);
    assign r  = 12'(win_reg[1][0]);
    assign bl = 12'(win_reg[2][c2i]);
    assign b  = 12'(win_reg[2][ci]);
    assign br = 12'(win_reg[2][0]);

    assign sum9 = tl + t + tr + l + c + r + bl + b + br;
    assign gsum = tl + tr + bl + br + ((t + l + r + b) << 1) + (c << 2);

    // Sharpen: 11c - 2(t+l+r+b), divided by 3 on its magnitude so that the
    // quotient truncates toward zero.
    assign sh_pos    = 14'(c) + (14'(c) << 1) + (14'(c) << 3);
    assign sh_neg    = (14'(t) + 14'(l) + 14'(r) + 14'(b)) << 1;
    assign sh_is_neg = sh_neg > sh_pos;
    assign sh_abs    = sh_is_neg ? 12'(sh_neg - sh_pos) : 12'(sh_pos - sh_neg);

    // One reciprocal multiplier serves both constant divisions.
    assign mul_a = (mode_reg == c3kf_pkg::MODE_SHARPEN) ? sh_abs : sum9;
    assign mul_k = (mode_reg == c3kf_pkg::MODE_SHARPEN) ? c3kf_pkg::RECIP_3
                                                          : c3kf_pkg::RECIP_9;
    assign prod  = mul_a * mul_k;
    assign quot  = prod[c3kf_pkg::RECIP_SHIFT +: 8];

    always_comb begin
        case (mode_reg)
            c3kf_pkg::MODE_SMOOTH:   kern_val = quot;
            c3kf_pkg::MODE_GAUSSIAN: kern_val = gsum[11:4];
            c3kf_pkg::MODE_SHARPEN:  kern_val = sh_is_neg ? 8'(8'd0 - quot) : quot;
            c3kf_pkg::MODE_EMBOSS:   kern_val = 8'(t - b);
            c3kf_pkg::MODE_MEAN_REM: kern_val = 8'((c << 3) + c - (sum9 - c));
            default:                 kern_val = c[7:0];
        endcase
    end

    always_comb begin
        case (p2_sel_reg)
            c3kf_pkg::SEL_KERNEL: res_val = kern_val;
            c3kf_pkg::SEL_CENTER: res_val = c[7:0];
            c3kf_pkg::SEL_EDGE:   res_val = p2_val_reg;
            c3kf_pkg::SEL_MID:    res_val = p2_val_reg;
            default:              res_val = p2_val_reg;
        endcase
    end

    logic [7:0] out_data_reg;
    logic       out_last_reg;

    always_ff @(posedge aclk) begin
        if (en2 && v2_reg) begin
            out_data_reg <= res_val;
            out_last_reg <= p2_eof_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end else begin
            if (en0) begin
                v1_reg <= item;
            end
            if (en1) begin
                v2_reg <= v1_reg && p1_emit_reg;
            end
            if (en2) begin
                out_v_reg <= v2_reg;
            end
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Write-back forwarding is only ever needed for grey frames.
    a_fwd_grey_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc && fwd_hit) |-> !ch3_reg)
        else $error("line store forwarding hit with three channels");

    // Column counters always address inside the current row.
    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (WC_W'(in_col_reg) < wc_reg) && (WC_W'(out_col_reg) < wc_reg))
        else $error("column counter beyond row length");

    // The input row never passes the second flush row.
    a_row_range: assert property (@(posedge aclk) disable iff (!aresetn)
        in_row_reg <= ({1'b0, h_reg} + 17'd1))
        else $error("input row counter beyond flush range");

    // The window only shifts for an item taken in during the frame.
    a_shift_src: assert property (@(posedge aclk) disable iff (!aresetn)
        up_we |-> (v1_reg && p1_shift_reg))
        else $error("window shift without a frame item in stage 1");

endmodule

`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for conv3x3_multi_kernel_filter: streams image bytes and
// compares each filtered byte with a line-store and window predictor kept in the bench.
// Depends on c3kf_pkg and the filter RTL only.

module tb_top;
    import c3kf_pkg::*;

    localparam int LANES_MAX     = DEF_MAX_CHANNELS;
    localparam int WIDTH_MAX     = DEF_MAX_WIDTH;
    localparam int STORE_DEPTH   = WIDTH_MAX * LANES_MAX;
    localparam int WIN_DEPTH     = 2 * LANES_MAX + 1;
    localparam int RANDOM_BYTES  = 1650;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_STALL    = 400;
    localparam int QUIET_LIMIT   = 2000;
    localparam int MAX_REPORTS   = 10;

    localparam logic [2:0] MODE_FIRST_UNUSED = MODE_MEAN_REM + 3'd1;
    localparam logic [2:0] MODE_CODE_MAX     = '1;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } filtered_byte_t;

    typedef enum int {FILL_RANDOM, FILL_RING_HIGH, FILL_CENTER_HIGH, FILL_EXTREMES} fill_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [7:0]            m_tdata;
    logic                  m_tlast;

    conv3x3_multi_kernel_filter u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Predictor state: register mirror, two line stores, the 3x3 window of every
    // channel, and the input and output raster positions.
    logic [2:0]  mode_r;
    logic [11:0] width_r;
    logic [15:0] height_r;
    logic        rgb_r;
    logic [7:0]  row_above [STORE_DEPTH];
    logic [7:0]  row_last  [STORE_DEPTH];
    logic [7:0]  win3      [3][WIN_DEPTH];
    int unsigned take_col, take_row, give_col, give_row;

    filtered_byte_t filtered_due[$];
    filtered_byte_t due_now;

    fill_t       fill_style = FILL_RANDOM;
    int unsigned bytes_sent = 0;
    int          mismatches = 0;
    int          tx_run = 0, rx_run = 0, rx_pause = 0, rx_gap = 0;
    bit          tx_calm = 1'b0, rx_calm = 1'b0;
    int          stall_orders = 0, stall_seen = 0, hold_left = 0;
    int          quiet_cycles = 0;

    function automatic int unsigned lanes();
        return (rgb_r && LANES_MAX >= 3) ? 3 : 1;
    endfunction

    // Sizes outside the legal range are clamped, as the block does.
    function automatic int unsigned cols();
        if (width_r < 3) return 3;
        if (width_r > WIDTH_MAX) return WIDTH_MAX;
        return width_r;
    endfunction

    function automatic int unsigned rows();
        return (height_r < 3) ? 3 : height_r;
    endfunction

    function automatic int unsigned frame_bytes();
        return cols() * rows() * lanes();
    endfunction

    function automatic void restart_frame();
        take_col = 0;
        take_row = 0;
        give_col = 0;
        give_row = 0;
    endfunction

    function automatic void clear_predictor();
        mode_r   = RST_MODE;
        width_r  = 12'(RST_WIDTH);
        height_r = 16'(RST_HEIGHT);
        rgb_r    = RST_THREE;
        for (int i = 0; i < STORE_DEPTH; i++) begin
            row_above[i] = '0;
            row_last[i]  = '0;
        end
        for (int r = 0; r < 3; r++)
            for (int i = 0; i < WIN_DEPTH; i++) win3[r][i] = '0;
        restart_frame();
    endfunction

    // Window column 0 holds the newest pixel (right), column ch the centre and
    // column 2*ch the left one; row 0 is the oldest image row.
    function automatic logic [7:0] apply_kernel(input int unsigned ch);
        int tl, t, tr, l, c, r, bl, b, br, v;
        tl = win3[0][2*ch]; t = win3[0][ch]; tr = win3[0][0];
        l  = win3[1][2*ch]; c = win3[1][ch]; r  = win3[1][0];
        bl = win3[2][2*ch]; b = win3[2][ch]; br = win3[2][0];
        case (mode_r)
            MODE_SMOOTH:   v = (tl + t + tr + l + c + r + bl + b + br) / 9;
            MODE_GAUSSIAN: v = (tl + 2*t + tr + 2*l + 4*c + 2*r + bl + 2*b + br) / 16;
            MODE_SHARPEN:  v = (11*c - 2*(t + l + r + b)) / 3;
            MODE_EMBOSS:   v = t - b;
            MODE_MEAN_REM: v = 9*c - (tl + t + tr + l + r + bl + b + br);
            default:       v = c;
        endcase
        return v[7:0];
    endfunction

    // Advances the predictor by one accepted item; returns 1 when the item
    // releases a filtered byte, which is then given in res and last.
    function automatic bit predict_filtered_byte(input logic [7:0] smp, input logic drn,
                                                 output logic [7:0] res, output logic last);
        int unsigned ch, wc, h, k;
        logic [7:0]  top, mid, edge_b;
        bit          emit, inner;
        ch   = lanes();
        wc   = cols() * ch;
        h    = rows();
        k    = (take_col >= wc) ? 0 : take_col;
        emit = 1'b0;
        res  = '0;
        last = 1'b0;
        if (take_row < h) begin
            // A drain before the whole frame is in does nothing at all.
            if (drn) return 1'b0;
            top    = row_above[k];
            mid    = row_last[k];
            edge_b = (k < ch) ? row_above[wc - ch + k] : 8'h00;
            row_above[k] = mid;
            row_last[k]  = smp;
            for (int i = WIN_DEPTH - 1; i > 0; i--) begin
                win3[0][i] = win3[0][i-1];
                win3[1][i] = win3[1][i-1];
                win3[2][i] = win3[2][i-1];
            end
            win3[0][0] = top;
            win3[1][0] = mid;
            win3[2][0] = smp;
            if (k >= ch) begin
                if (take_row >= 1) begin
                    inner = give_row >= 1 && give_row + 1 < h &&
                            give_col >= ch && give_col + ch < wc;
                    emit  = 1'b1;
                    res   = inner ? apply_kernel(ch) : win3[1][ch];
                end
            end else if (take_row >= 2) begin
                // The last pixel of the previous row is a right border pixel.
                emit = 1'b1;
                res  = edge_b;
            end
        end else begin
            // Flushing: every item pushes out one byte of the held tail.
            emit = 1'b1;
            if (take_row == h)
                res = (k < ch) ? row_above[wc - ch + k] : row_last[k - ch];
            else
                res = row_last[(k < ch) ? wc - ch + k : k];
        end
        k++;
        if (k >= wc) begin
            k = 0;
            take_row++;
        end
        take_col = k;
        if (!emit) return 1'b0;
        last = (give_row + 1 >= h) && (give_col + 1 >= wc);
        if (last) begin
            restart_frame();
        end else begin
            give_col++;
            if (give_col >= wc) begin
                give_col = 0;
                give_row++;
            end
        end
        return 1'b1;
    endfunction

    // Draws the idle time before the next item, with calm stretches of no idling.
    function automatic int draw_pause(inout int run, inout bit calm);
        if (run == 0) begin
            run  = $urandom_range(8, 60);
            calm = ($urandom_range(0, 3) == 0);
        end
        run--;
        return calm ? 0 : $urandom_range(0, 5);
    endfunction

    // FILL_RING_HIGH and FILL_CENTER_HIGH mark the centre of a 3x3 grey frame.
    function automatic logic [7:0] sample_for(input int unsigned n);
        case (fill_style)
            FILL_RING_HIGH:   return (n == 4) ? 8'h00 : 8'hFF;
            FILL_CENTER_HIGH: return (n == 4) ? 8'hFF : 8'h00;
            FILL_EXTREMES:    return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default:          return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("%0t: mismatch: %s", $time, msg);
    endtask

    task automatic send_byte(input logic [7:0] smp, input logic drn);
        int         pause;
        logic [7:0] res;
        logic       last;
        pause = draw_pause(tx_run, tx_calm);
        if (pause > 0) begin
            s_tvalid <= 1'b0;
            repeat (pause) @(posedge aclk);
        end
        s_tdata  <= smp;
        s_tuser  <= drn;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
        if (predict_filtered_byte(smp, drn, res, last)) filtered_due.push_back({res, last});
    endtask

    // Frame bytes, with drain items slipped in at random; those are ignored.
    task automatic send_pixels(input int unsigned n, input int drain_pct);
        for (int unsigned i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < drain_pct) send_byte(8'($urandom_range(0, 255)), 1'b1);
            send_byte(sample_for(i), 1'b0);
        end
    endtask

    // Flush until the last byte of the frame is out; byte_pct of the flush items
    // are plain bytes, which the block must treat as drains.
    task automatic flush_frame(input int byte_pct);
        while (take_row >= rows())
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 99) >= byte_pct);
    endtask

    task automatic send_frame(input int drain_pct, input int byte_pct);
        send_pixels(frame_bytes(), drain_pct);
        flush_frame(byte_pct);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (filtered_due.size() != 0) @(posedge aclk);
        // Items that give no byte may still be in the pipeline.
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_FILTER_MODE:    mode_r   = data[2:0];
            CFG_IMAGE_WIDTH:    width_r  = data[11:0];
            CFG_IMAGE_HEIGHT:   height_r = data;
            CFG_THREE_CHANNELS: rgb_r    = data[0];
        endcase
        restart_frame();
        @(posedge aclk);
    endtask

    // Writes all four registers in a random order; unused data bits sometimes
    // carry junk that the registers must drop.
    task automatic set_format(input logic [2:0] mode, input int width, input int height,
                              input bit rgb);
        logic [CFG_IDX_W-1:0]  order [4];
        logic [CFG_IDX_W-1:0]  tmp;
        logic [CFG_DATA_W-1:0] junk;
        int                    j;
        order = '{CFG_FILTER_MODE, CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT, CFG_THREE_CHANNELS};
        for (int i = 3; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < 4; i++) begin
            junk = ($urandom_range(0, 3) == 0) ? 16'($urandom) : '0;
            case (order[i])
                CFG_FILTER_MODE:  write_register(order[i], {junk[15:3], mode});
                CFG_IMAGE_WIDTH:  write_register(order[i], {junk[15:12], 12'(width)});
                CFG_IMAGE_HEIGHT: write_register(order[i], 16'(height));
                default:          write_register(order[i], {junk[15:1], rgb});
            endcase
        end
    endtask

    // Reset values: 640 wide RGB smooth. Two rows and a bit reach the kernel on
    // the second output row without a whole frame.
    task automatic test_reset_defaults();
        fill_style = FILL_RANDOM;
        send_pixels(cols() * lanes() * 2 + 60, 0);
        wait_idle();
    endtask

    // Each kernel on a 3x3 grey frame whose one inner pixel differs at full scale from the rest.
    task automatic test_kernels();
        for (int m = MODE_SMOOTH; m <= MODE_MEAN_REM; m++) begin
            set_format(3'(m), 3, 3, 1'b0);
            fill_style = (m % 2 == 0) ? FILL_RING_HIGH : FILL_CENTER_HIGH;
            send_frame(0, 0);
            wait_idle();
        end
    endtask

    task automatic test_special_cases();
        // Width and height below the minimum clamp to 3; early drains are ignored
        // and plain bytes sent while flushing act as drains.
        set_format(MODE_SHARPEN, 1, 0, 1'b1);
        fill_style = FILL_EXTREMES;
        send_byte(8'hFF, 1'b1);
        send_pixels(frame_bytes(), 30);
        flush_frame(50);
        wait_idle();
        // A register write in mid frame restarts it; then two frames back to back.
        set_format(MODE_EMBOSS, 5, 4, 1'b0);
        fill_style = FILL_RANDOM;
        send_pixels(13, 0);
        wait_idle();
        set_format(MODE_GAUSSIAN, 0, 4, 1'b1);
        write_register(CFG_IMAGE_WIDTH, 16'd5);
        send_frame(5, 20);
        send_frame(5, 20);
        wait_idle();
    endtask

    // The receiver holds off for a long stretch while bytes keep coming.
    task automatic test_backpressure();
        set_format(MODE_MEAN_REM, 8, 6, 1'b1);
        fill_style = FILL_RANDOM;
        stall_orders++;
        send_frame(3, 20);
        wait_idle();
    endtask

    task automatic test_large_frames();
        fill_style = FILL_RANDOM;
        set_format(MODE_MEAN_REM, WIDTH_MAX, 3, 1'b1);
        send_frame(1, 10);
        wait_idle();
        // All-ones width clamps to the maximum.
        set_format(MODE_SHARPEN, 4095, 3, 1'b0);
        send_frame(1, 10);
        wait_idle();
        // Tallest frame: only its first rows, then the next write restarts it.
        set_format(MODE_GAUSSIAN, 3, 65535, 1'b0);
        send_pixels(30, 0);
        wait_idle();
    endtask

    task automatic test_random_frames();
        int unsigned first;
        logic [2:0]  mode;
        int          w, h, frames;
        first = bytes_sent;
        while (bytes_sent - first < RANDOM_BYTES) begin
            mode = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(MODE_FIRST_UNUSED, MODE_CODE_MAX))
                                               : 3'($urandom_range(MODE_SMOOTH, MODE_MEAN_REM));
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
            h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
            set_format(mode, w, h, 1'($urandom_range(0, 1)));
            frames = $urandom_range(1, 3);
            for (int f = 0; f < frames; f++) begin
                fill_style = ($urandom_range(0, 3) == 0) ? FILL_EXTREMES : FILL_RANDOM;
                if ($urandom_range(0, 7) == 0) begin
                    // Broken frame, cut off by the next register write.
                    send_pixels($urandom_range(1, frame_bytes() - 1), 5);
                    break;
                end
                send_frame(3, 15);
            end
            wait_idle();
        end
    endtask

    // Result side ready: random gaps per item, plus the long hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            rx_gap     <= 0;
            hold_left  <= 0;
            stall_seen <= 0;
        end else if (stall_orders != stall_seen) begin
            stall_seen <= stall_orders;
            hold_left  <= LONG_STALL;
            m_tready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= (hold_left == 1);
        end else if (m_tready && m_tvalid) begin
            rx_pause = draw_pause(rx_run, rx_calm);
            m_tready <= (rx_pause == 0);
            rx_gap   <= rx_pause;
        end else if (!m_tready) begin
            if (rx_gap <= 1) m_tready <= 1'b1;
            rx_gap <= (rx_gap > 0) ? rx_gap - 1 : 0;
        end
    end

    // Each result item is checked against the oldest pending filtered byte.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (filtered_due.size() == 0) begin
                flag_mismatch($sformatf("result %02h/%0b with nothing pending", m_tdata, m_tlast));
            end else begin
                due_now = filtered_due.pop_front();
                if (m_tdata !== due_now.value)
                    flag_mismatch($sformatf("result_sample expected %02h got %02h",
                                            due_now.value, m_tdata));
                if (m_tlast !== due_now.last)
                    flag_mismatch($sformatf("end_of_frame expected %0b got %0b",
                                            due_now.last, m_tlast));
            end
        end
    end

    // Ends the run when no channel has moved an item for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        clear_predictor();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_kernels();
        test_special_cases();
        test_backpressure();
        test_large_frames();
        test_random_frames();
        wait_idle();
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && filtered_due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: conv3x3_multi_kernel_filter.f
rtl/c3kf_pkg.sv
rtl/conv3x3_multi_kernel_filter.sv
verif/tb_top.sv
